>>> src/mcc_pkg.sv
// ---------------------------------------------------------------------------
// mcc_pkg
// Types and constants shared by the MIDI parser / chord capture block.
// ---------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

   // largest chord emitted for one request
   localparam int RESULT_LIMIT = 16;

   localparam logic [7:0] BYTE_CLOCK    = 8'hF8;
   localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
   localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
   localparam logic [3:0] NIB_CTRL      = 4'hB;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_CLOCK = 2'd1,
      EV_CTRL  = 2'd2,
      EV_NOTE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CMD_CLOCK,
      CMD_CTRL,
      CMD_PRESS,
      CMD_RELEASE
   } cmd_type;

   typedef enum logic [1:0] {
      PH_STATUS,
      PH_DATA1,
      PH_DATA2
   } phase_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [6:0] num;
      logic [6:0] val;
   } cmd_entry_type;

endpackage

`default_nettype wire

>>> src/mcc_front.sv
// ---------------------------------------------------------------------------
// mcc_front
// Running status parser: classifies raw bytes into commands for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module mcc_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire  [7:0]             req_midi_byte,
   input  wire                    q_full,
   output logic                   q_push,
   output mcc_pkg::cmd_entry_type q_entry
);

   mcc_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         status_ff, status_in;
   logic [6:0]         first_ff, first_in;
   logic               cmd_vld;
   logic               accept;
   logic [3:0]         hi_nib;

   assign hi_nib    = status_ff[7:4];
   assign req_stall = cmd_vld && q_full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = accept && cmd_vld;

   // next state
   always_comb begin
      phase_in  = phase_ff;
      status_in = status_ff;
      first_in  = first_ff;
      if (accept && req_midi_byte != mcc_pkg::BYTE_CLOCK) begin
         if (req_midi_byte[7]) begin
            status_in = req_midi_byte;
            phase_in  = mcc_pkg::PH_DATA1;
         end else begin
            unique case (phase_ff)
               mcc_pkg::PH_DATA1: begin
                  first_in = req_midi_byte[6:0];
                  phase_in = mcc_pkg::PH_DATA2;
               end
               mcc_pkg::PH_DATA2: phase_in = mcc_pkg::PH_DATA1;
               default:           phase_in = phase_ff;
            endcase
         end
      end
   end

   // classification of the current byte
   always_comb begin
      cmd_vld       = 1'b0;
      q_entry.cmd   = mcc_pkg::CMD_CLOCK;
      q_entry.num   = 7'd0;
      q_entry.val   = 7'd0;
      if (req_midi_byte == mcc_pkg::BYTE_CLOCK) begin
         cmd_vld = 1'b1;
      end else if (!req_midi_byte[7] && phase_ff == mcc_pkg::PH_DATA2) begin
         q_entry.num = first_ff;
         q_entry.val = req_midi_byte[6:0];
         if (hi_nib == mcc_pkg::NIB_NOTE_ON && req_midi_byte != 8'd0) begin
            cmd_vld     = 1'b1;
            q_entry.cmd = mcc_pkg::CMD_PRESS;
         end else if (hi_nib == mcc_pkg::NIB_NOTE_OFF || hi_nib == mcc_pkg::NIB_NOTE_ON) begin
            cmd_vld     = 1'b1;
            q_entry.cmd = mcc_pkg::CMD_RELEASE;
         end else if (hi_nib == mcc_pkg::NIB_CTRL) begin
            cmd_vld     = 1'b1;
            q_entry.cmd = mcc_pkg::CMD_CTRL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= mcc_pkg::PH_STATUS;
         status_ff <= 8'd0;
         first_ff  <= 7'd0;
      end else begin
         phase_ff  <= phase_in;
         status_ff <= status_in;
         first_ff  <= first_in;
      end
   end

endmodule

`default_nettype wire

>>> src/mcc_queue.sv
// ---------------------------------------------------------------------------
// mcc_queue
// Two-entry command queue between parser and chord engine.
// ---------------------------------------------------------------------------
`default_nettype none

module mcc_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  mcc_pkg::cmd_entry_type push_entry,
   output logic                   full,
   input  wire                    pop,
   output logic                   empty,
   output mcc_pkg::cmd_entry_type head_entry
);

   mcc_pkg::cmd_entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign empty      = (count_ff == 2'd0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)
         count_in = count_ff + 2'd1;
      else if (pop && !push)
         count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

`default_nettype wire

>>> src/mcc_back.sv
// ---------------------------------------------------------------------------
// mcc_back
// Chord engine: keeps the capture set, checks duplicates, plays out chords.
// ---------------------------------------------------------------------------
`default_nettype none

module mcc_back #(
   parameter int Capacity = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    q_empty,
   input  mcc_pkg::cmd_entry_type q_entry,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output logic [1:0]             rsp_event_kind,
   output logic [6:0]             rsp_number_field,
   output logic [6:0]             rsp_value_field,
   output logic [3:0]             rsp_chord_position,
   output logic                   rsp_last_of_run
);

   localparam int CNT_W = $clog2(Capacity + 1);
   localparam int IDX_W = (Capacity > 1) ? $clog2(Capacity) : 1;

   mcc_pkg::back_state_type state_ff, state_in;

   logic [6:0]       notes_ff [Capacity];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             active_ff, active_in;
   logic [6:0]       lead_ff, lead_in;
   logic [6:0]       key_ff, key_in;

   logic             rsp_valid_ff, rsp_valid_in;
   mcc_pkg::kind_type kind_ff, kind_in;
   logic [6:0]       num_ff, num_in;
   logic [6:0]       val_ff, val_in;
   logic [3:0]       pos_ff, pos_in;
   logic             last_ff, last_in;

   logic             out_free;
   logic [6:0]       cur_note;
   logic             scan_end;
   logic             emit_last;
   logic             lead_hit;
   logic             note_we;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cur_note  = notes_ff[scan_ff[IDX_W-1:0]];
   assign scan_end  = (scan_ff == count_ff);
   assign emit_last = ((scan_ff + CNT_W'(1)) == count_ff);
   assign lead_hit  = active_ff && (q_entry.num == lead_ff) && (count_ff != '0);

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_kind     = kind_ff;
   assign rsp_number_field   = num_ff;
   assign rsp_value_field    = val_ff;
   assign rsp_chord_position = pos_ff;
   assign rsp_last_of_run    = last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mcc_pkg::BK_IDLE: begin
            if (!q_empty) begin
               if (q_entry.cmd == mcc_pkg::CMD_PRESS)
                  state_in = mcc_pkg::BK_SCAN;
               else if (q_entry.cmd == mcc_pkg::CMD_RELEASE && lead_hit)
                  state_in = mcc_pkg::BK_EMIT;
            end
         end
         mcc_pkg::BK_SCAN: begin
            if (scan_end || cur_note == key_ff)
               state_in = mcc_pkg::BK_IDLE;
         end
         mcc_pkg::BK_EMIT: begin
            if (out_free && emit_last)
               state_in = mcc_pkg::BK_IDLE;
         end
         default: state_in = mcc_pkg::BK_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      q_pop        = 1'b0;
      note_we      = 1'b0;
      count_in     = count_ff;
      scan_in      = scan_ff;
      active_in    = active_ff;
      lead_in      = lead_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      num_in       = num_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      unique case (state_ff)
         mcc_pkg::BK_IDLE: begin
            if (!q_empty) begin
               case (q_entry.cmd)
                  mcc_pkg::CMD_CLOCK, mcc_pkg::CMD_CTRL: begin
                     if (out_free) begin
                        q_pop        = 1'b1;
                        rsp_valid_in = 1'b1;
                        pos_in       = 4'd0;
                        last_in      = 1'b1;
                        if (q_entry.cmd == mcc_pkg::CMD_CLOCK) begin
                           kind_in = mcc_pkg::EV_CLOCK;
                           num_in  = 7'd0;
                           val_in  = 7'd0;
                        end else begin
                           kind_in = mcc_pkg::EV_CTRL;
                           num_in  = q_entry.num;
                           val_in  = q_entry.val;
                        end
                     end
                  end
                  mcc_pkg::CMD_PRESS: begin
                     q_pop   = 1'b1;
                     key_in  = q_entry.num;
                     scan_in = '0;
                     // first note opens a fresh capture
                     if (!active_ff) begin
                        active_in = 1'b1;
                        lead_in   = q_entry.num;
                        count_in  = '0;
                     end
                  end
                  default: begin
                     q_pop   = 1'b1;
                     scan_in = '0;
                     if (lead_hit)
                        active_in = 1'b0;
                  end
               endcase
            end
         end
         mcc_pkg::BK_SCAN: begin
            if (scan_end) begin
               if (count_ff < CNT_W'(Capacity)) begin
                  note_we  = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end else if (cur_note != key_ff) begin
               scan_in = scan_ff + CNT_W'(1);
            end
         end
         mcc_pkg::BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = mcc_pkg::EV_NOTE;
               num_in       = cur_note;
               val_in       = 7'd0;
               pos_in       = 4'(scan_ff);
               last_in      = emit_last;
               scan_in      = scan_ff + CNT_W'(1);
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcc_pkg::BK_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         active_ff    <= 1'b0;
         lead_ff      <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         active_ff    <= active_in;
         lead_ff      <= lead_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      kind_ff <= kind_in;
      num_ff  <= num_in;
      val_ff  <= val_in;
      pos_ff  <= pos_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (note_we)
         notes_ff[count_ff[IDX_W-1:0]] <= key_ff;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(Capacity))
      else $error("capture count above capacity");

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == mcc_pkg::BK_EMIT |-> scan_ff < count_ff)
      else $error("chord playout index past fill count");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == mcc_pkg::BK_SCAN |-> scan_ff <= count_ff)
      else $error("duplicate scan index past fill count");

   a_active_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcc_pkg::BK_IDLE && active_ff) |-> count_ff != '0)
      else $error("open capture without lead note");

   a_valid_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> kind_ff != mcc_pkg::EV_NONE)
      else $error("result with no event kind");

endmodule

`default_nettype wire

>>> src/midi_parser_chord_capture.sv
// ---------------------------------------------------------------------------
// midi_parser_chord_capture
// MIDI running status parser with clock, control change and chord capture.
//
//   channel  ports                         carries
//   req      req_valid / req_stall         one raw MIDI byte per request
//   rsp      rsp_valid / rsp_stall         clock, controller or chord note
//
// A byte that yields no command is taken every cycle; a command waits only
// while the two-entry queue is full.
// Clock and controller commands leave the engine from idle once the output is free.
// A note-on walks the capture set one entry a cycle and stops at a duplicate.
// A closing note-off plays out the chord one note a cycle unless rsp_stall holds it.
// Synchronous reset empties queue and capture; rsp_stall freezes the output.
// ---------------------------------------------------------------------------
`default_nettype none

module midi_parser_chord_capture #(
   parameter int MAX_CHORD_NOTES = 16
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [7:0] req_midi_byte,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [1:0] rsp_event_kind,
   output logic [6:0] rsp_number_field,
   output logic [6:0] rsp_value_field,
   output logic [3:0] rsp_chord_position,
   output logic       rsp_last_of_run
);

   localparam int CAPACITY = (MAX_CHORD_NOTES < mcc_pkg::RESULT_LIMIT) ?
                             MAX_CHORD_NOTES : mcc_pkg::RESULT_LIMIT;

   logic                   q_push;
   logic                   q_full;
   logic                   q_pop;
   logic                   q_empty;
   mcc_pkg::cmd_entry_type push_entry;
   mcc_pkg::cmd_entry_type head_entry;

   mcc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_midi_byte (req_midi_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (push_entry)
   );

   mcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head_entry (head_entry)
   );

   mcc_back #(
      .Capacity (CAPACITY)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .q_entry            (head_entry),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_number_field   (rsp_number_field),
      .rsp_value_field    (rsp_value_field),
      .rsp_chord_position (rsp_chord_position),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

`default_nettype wire
